// ----- rtl/frc_pkg.sv -----
// Shared types, constants and codes for the framed remote control receiver.
`default_nettype none
package frc_pkg;

  localparam int unsigned PAYLOAD_MAX_DEF = 16;
  localparam int unsigned CONTROL_LEN     = 7;
  localparam int unsigned CTRL_IDX_W      = $clog2(CONTROL_LEN);
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_CONTROL    = 3'd1,
    ST_CONNECT    = 3'd2,
    ST_DISCONNECT = 3'd3,
    ST_OTHER      = 3'd4,
    ST_BADSUM     = 3'd5,
    ST_TOOLONG    = 3'd6
  } frame_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST   = 3'd0,
    REG_HEADER_SECOND  = 3'd1,
    REG_CONTROL_TYPE   = 3'd2,
    REG_EVENT_TYPE     = 3'd3,
    REG_CONNECT_CODE   = 3'd4,
    REG_DISCONNECT_CODE = 3'd5,
    REG_SIGNAL_LOST    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  control_type;
    logic [7:0]  event_type;
    logic [7:0]  connect_code;
    logic [7:0]  disconnect_code;
    logic [15:0] signal_lost_ticks;
  } cfg_t;

  typedef logic [CONTROL_LEN-1:0][7:0] ctrl_bytes_t;

  // Frame result handed from the parser to the control register bank.
  typedef struct packed {
    frame_status_e status;
    logic          load_ctrl;
    logic          set_conn;
    logic          clr_conn;
  } frame_evt_t;

endpackage
`default_nettype wire

// ----- rtl/frc_parser.sv -----
// Frame parser: header match, length check, payload capture and XOR checksum.
`default_nettype none
module frc_parser #(
  parameter int unsigned PAYLOAD_MAX = frc_pkg::PAYLOAD_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               byte_step_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire frc_pkg::cfg_t      cfg_i,
  output frc_pkg::frame_evt_t     evt_o,
  output frc_pkg::ctrl_bytes_t    payload_o
);
  import frc_pkg::*;

  localparam int unsigned LEN_W = $clog2(PAYLOAD_MAX + 1);

  typedef enum logic [5:0] {
    PH_H1   = 6'b000001,
    PH_H2   = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_CHK  = 6'b100000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        type_q, type_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  pos_inc;
  logic [7:0]        sum_q, sum_d;
  ctrl_bytes_t       store_q;
  logic              store_we;
  frame_evt_t        evt;

  assign pos_inc = pos_q + LEN_W'(1);

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    len_d    = len_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    store_we = 1'b0;
    evt      = '{status: ST_NONE, load_ctrl: 1'b0, set_conn: 1'b0, clr_conn: 1'b0};
    unique case (phase_q)
      PH_H1: begin
        sum_d = '0;
        if (rx_byte_i == cfg_i.header_first) phase_d = PH_H2;
      end
      PH_H2: begin
        phase_d = (rx_byte_i == cfg_i.header_second) ? PH_TYPE : PH_H1;
      end
      PH_TYPE: begin
        type_d  = rx_byte_i;
        sum_d   = rx_byte_i;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        sum_d = sum_q ^ rx_byte_i;
        if (rx_byte_i > 8'(PAYLOAD_MAX)) begin
          phase_d    = PH_H1;
          evt.status = ST_TOOLONG;
        end else begin
          len_d   = rx_byte_i[LEN_W-1:0];
          pos_d   = '0;
          phase_d = (rx_byte_i == 8'd0) ? PH_CHK : PH_DATA;
        end
      end
      PH_DATA: begin
        // Only the leading control-length bytes are ever read back.
        store_we = (pos_q < LEN_W'(CONTROL_LEN));
        pos_d    = pos_inc;
        sum_d    = sum_q ^ rx_byte_i;
        if (pos_inc >= len_q) phase_d = PH_CHK;
      end
      PH_CHK: begin
        phase_d = PH_H1;
        if (rx_byte_i != sum_q) begin
          evt.status = ST_BADSUM;
        end else if (type_q == cfg_i.control_type && len_q == LEN_W'(CONTROL_LEN)) begin
          evt.status    = ST_CONTROL;
          evt.load_ctrl = 1'b1;
        end else if (type_q == cfg_i.event_type && len_q == LEN_W'(1)
                     && store_q[0] == cfg_i.connect_code) begin
          evt.status   = ST_CONNECT;
          evt.set_conn = 1'b1;
        end else if (type_q == cfg_i.event_type && len_q == LEN_W'(1)
                     && store_q[0] == cfg_i.disconnect_code) begin
          evt.status   = ST_DISCONNECT;
          evt.clr_conn = 1'b1;
        end else begin
          evt.status = ST_OTHER;
        end
      end
      default: begin
        phase_d = PH_H1;
      end
    endcase
    if (!byte_step_i) begin
      phase_d  = phase_q;
      type_d   = type_q;
      len_d    = len_q;
      pos_d    = pos_q;
      sum_d    = sum_q;
      store_we = 1'b0;
      evt      = '{status: ST_NONE, load_ctrl: 1'b0, set_conn: 1'b0, clr_conn: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_H1;
      type_q  <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_q[pos_q[CTRL_IDX_W-1:0]] <= rx_byte_i;
  end

  assign evt_o     = evt;
  assign payload_o = store_q;

endmodule
`default_nettype wire

// ----- rtl/frc_ctrl_regs.sv -----
// Control field bank, connected flag and idle tick counter with signal-lost clear.
`default_nettype none
module frc_ctrl_regs (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 tick_i,
  input  wire frc_pkg::frame_evt_t  evt_i,
  input  wire frc_pkg::ctrl_bytes_t payload_i,
  input  wire logic [15:0]          signal_lost_ticks_i,
  output frc_pkg::ctrl_bytes_t      fields_o,
  output logic                      connected_o,
  output logic                      alive_o
);
  import frc_pkg::*;

  ctrl_bytes_t fields_q, fields_d;
  logic        conn_q, conn_d;
  logic [15:0] idle_q, idle_d;
  logic        alive_q, alive_d;

  always_comb begin
    fields_d = fields_q;
    conn_d   = conn_q;
    idle_d   = idle_q;
    if (tick_i) begin
      if (idle_q != 16'hFFFF) idle_d = idle_q + 16'd1;
    end
    if (evt_i.load_ctrl) begin
      fields_d = payload_i;
      idle_d   = '0;
    end
    if (evt_i.set_conn) conn_d = 1'b1;
    if (evt_i.clr_conn) conn_d = 1'b0;
    alive_d = (idle_d <= signal_lost_ticks_i);
    if (!alive_d) fields_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= '0;
      conn_q   <= 1'b0;
      idle_q   <= '0;
      alive_q  <= 1'b1;
    end else if (step_i) begin
      fields_q <= fields_d;
      conn_q   <= conn_d;
      idle_q   <= idle_d;
      alive_q  <= alive_d;
    end
  end

  assign fields_o    = fields_q;
  assign connected_o = conn_q;
  assign alive_o     = alive_q;

endmodule
`default_nettype wire

// ----- rtl/framed_remote_control_receiver_core.sv -----
// Top level of the framed remote control receiver: input stage, config, result register.
// Timing: an accepted transaction is held in the input stage register and is processed
//   when the result slot is free; its result is then registered and shown on the output channel.
// Throughput: one transaction per cycle while the result channel is not stalled.
// Reset: asynchronous, active low; parser waits for the first header, control fields,
//   connected flag and idle counter clear, alive flag sets, config registers take their default values.
`default_nettype none
module framed_remote_control_receiver_core #(
  parameter int unsigned PAYLOAD_MAX = frc_pkg::PAYLOAD_MAX_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           operation_i,
  input  wire logic [7:0]                     rx_byte_i,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [frc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [7:0]                          buttons_o,
  output logic [7:0]                          misc_buttons_o,
  output logic [7:0]                          dpad_o,
  output logic signed [7:0]                   left_x_o,
  output logic signed [7:0]                   left_y_o,
  output logic signed [7:0]                   right_x_o,
  output logic signed [7:0]                   right_y_o,
  output logic                                connected_o,
  output logic                                link_alive_o,
  output logic [2:0]                          frame_status_o
);
  import frc_pkg::*;

  // Input stage: hold one transaction while the result register is stalled.
  logic       in_valid_q;
  logic       op_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       step;

  cfg_t          cfg_q;
  frame_evt_t    evt;
  ctrl_bytes_t   payload;
  ctrl_bytes_t   fields;
  frame_status_e status_q;

  // Advance when the input stage holds a transaction and the result slot is free.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= operation_i;
      byte_q <= rx_byte_i;
    end
  end

  // Configuration registers: always ready, writes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first      <= 8'd170;
      cfg_q.header_second     <= 8'd85;
      cfg_q.control_type      <= 8'd1;
      cfg_q.event_type        <= 8'd2;
      cfg_q.connect_code      <= 8'd1;
      cfg_q.disconnect_code   <= 8'd2;
      cfg_q.signal_lost_ticks <= 16'd500;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEADER_FIRST:    cfg_q.header_first      <= cfg_data_i[7:0];
        REG_HEADER_SECOND:   cfg_q.header_second     <= cfg_data_i[7:0];
        REG_CONTROL_TYPE:    cfg_q.control_type      <= cfg_data_i[7:0];
        REG_EVENT_TYPE:      cfg_q.event_type        <= cfg_data_i[7:0];
        REG_CONNECT_CODE:    cfg_q.connect_code      <= cfg_data_i[7:0];
        REG_DISCONNECT_CODE: cfg_q.disconnect_code   <= cfg_data_i[7:0];
        REG_SIGNAL_LOST:     cfg_q.signal_lost_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte transactions feed the parser; ticks only advance the idle counter.
  frc_parser #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_step_i(step && !op_q),
    .rx_byte_i  (byte_q),
    .cfg_i      (cfg_q),
    .evt_o      (evt),
    .payload_o  (payload)
  );

  frc_ctrl_regs u_ctrl_regs (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .tick_i             (op_q),
    .evt_i              (evt),
    .payload_i          (payload),
    .signal_lost_ticks_i(cfg_q.signal_lost_ticks),
    .fields_o           (fields),
    .connected_o        (connected_o),
    .alive_o            (link_alive_o)
  );

  // Result register: the register bank doubles as the held result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_NONE;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        status_q    <= evt.status;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign buttons_o      = fields[0];
  assign misc_buttons_o = fields[1];
  assign dpad_o         = fields[2];
  assign left_x_o       = $signed(fields[3]);
  assign left_y_o       = $signed(fields[4]);
  assign right_x_o      = $signed(fields[5]);
  assign right_y_o      = $signed(fields[6]);

  // Lost link always shows cleared control data.
  a_lost_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_alive_o |-> (fields == '0))
    else $error("control fields not cleared while link lost");

  // An applied control frame restarts the idle counter, so the link is alive.
  a_control_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ST_CONTROL) |-> link_alive_o)
    else $error("control frame applied but link reported lost");

  a_connect_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ST_CONNECT) |-> connected_o)
    else $error("connect status without connected flag");

  a_disconnect_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ST_DISCONNECT) |-> !connected_o)
    else $error("disconnect status with connected flag set");

  // A tick never carries a frame status.
  a_tick_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && op_q) |=> (frame_status_o == ST_NONE))
    else $error("tick produced a frame status");

endmodule
`default_nettype wire
